// ===== rtl/core/envelope_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// envelope_deframer_macros
// Assertion macros for the envelope deframer.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_DEFRAMER_MACROS_SVH
`define ENVELOPE_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ED_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define ED_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/ed_pkg.sv =====
// ----------------------------------------------------------------------------
// ed_pkg
// Shared types and constants of the envelope deframer.
// ----------------------------------------------------------------------------
package ed_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned HDR_BYTES   = 12;
	localparam int unsigned HDR_SHIFT_W = (HDR_BYTES - 1) * BYTE_W;
	localparam int unsigned HDR_CNT_W   = 4;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TDATA_W     = 3 * WORD_W + BYTE_W;

	localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HDR_BYTES - 1);

	localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;
	localparam logic [0:0] REG_BUFFER_SIZE = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_BYTE   = 2'd1,
		OP_ERROR  = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic {
		PH_HEADER  = 1'b0,
		PH_PAYLOAD = 1'b1
	} phase_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] win_id;
		logic [WORD_W-1:0] msg_type;
		logic [WORD_W-1:0] length;
		logic [BYTE_W-1:0] data_byte;
	} op_entry_t;

endpackage

// ===== rtl/core/ed_front.sv =====
// ----------------------------------------------------------------------------
// ed_front
// Gathers the frame header, checks the length limit and tracks frame bytes.
// ----------------------------------------------------------------------------
module ed_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     action,
	input  logic [ed_pkg::BYTE_W-1:0] data_byte,
	input  logic [ed_pkg::WORD_W-1:0] max_payload,
	input  logic                     q_full,
	output logic                     in_ready,
	output logic                     push,
	output ed_pkg::op_entry_t        push_entry
);
	import ed_pkg::*;

	logic [HDR_SHIFT_W-1:0] hdr_q;
	logic [HDR_CNT_W-1:0]   hdr_cnt_q;
	phase_t                 phase_q;
	logic [WORD_W-1:0]      frame_left_q;

	logic              accept;
	logic [WORD_W-1:0] len;
	logic              over;
	logic              hdr_done;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign len      = {hdr_q[3*BYTE_W-1:0], data_byte};
	assign over     = len > max_payload;
	assign hdr_done = (phase_q == PH_HEADER) && (hdr_cnt_q == HDR_LAST_IDX);

	always_comb begin
		push_entry = '0;
		push       = 1'b0;
		if (action) begin
			push_entry.op = OP_END;
			push          = accept;
		end else if (phase_q == PH_PAYLOAD) begin
			push_entry.op        = OP_BYTE;
			push_entry.data_byte = data_byte;
			push                 = accept;
		end else if (hdr_done) begin
			push_entry.op        = over ? OP_ERROR : OP_HEADER;
			push_entry.win_id    = hdr_q[HDR_SHIFT_W-1 -: WORD_W];
			push_entry.msg_type  = hdr_q[HDR_SHIFT_W-WORD_W-1 -: WORD_W];
			push_entry.length    = len;
			push                 = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q        <= '0;
			hdr_cnt_q    <= '0;
			phase_q      <= PH_HEADER;
			frame_left_q <= '0;
		end else if (accept) begin
			if (action) begin
				hdr_q        <= '0;
				hdr_cnt_q    <= '0;
				phase_q      <= PH_HEADER;
				frame_left_q <= '0;
			end else if (phase_q == PH_PAYLOAD) begin
				frame_left_q <= frame_left_q - 1'b1;
				if (frame_left_q == WORD_W'(1)) begin
					phase_q <= PH_HEADER;
				end
			end else if (hdr_done) begin
				hdr_q     <= '0;
				hdr_cnt_q <= '0;
				if (!over && len != '0) begin
					phase_q      <= PH_PAYLOAD;
					frame_left_q <= len;
				end
			end else begin
				hdr_q     <= {hdr_q[HDR_SHIFT_W-BYTE_W-1:0], data_byte};
				hdr_cnt_q <= hdr_cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ed_queue.sv =====
// ----------------------------------------------------------------------------
// ed_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module ed_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ed_pkg::op_entry_t push_entry,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output ed_pkg::op_entry_t head
);
	import ed_pkg::*;

	op_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/ed_back.sv =====
// ----------------------------------------------------------------------------
// ed_back
// Turns queued items into results: trims the kept length, passes kept bytes.
// ----------------------------------------------------------------------------
module ed_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_not_empty,
	input  ed_pkg::op_entry_t         q_head,
	input  logic [ed_pkg::WORD_W-1:0] buffer_size,
	input  logic                      out_ready,
	output logic                      pop,
	output logic                      out_valid,
	output ed_pkg::kind_t             out_kind,
	output logic [ed_pkg::TDATA_W-1:0] out_data,
	output logic                      out_last
);
	import ed_pkg::*;

	logic [WORD_W-1:0]  keep_left_q;
	logic               valid_q;
	kind_t              kind_q;
	logic [TDATA_W-1:0] data_q;
	logic               last_q;

	logic               load_ok;
	logic [WORD_W-1:0]  keep;
	logic               emit;
	kind_t              nxt_kind;
	logic [TDATA_W-1:0] nxt_data;
	logic               nxt_last;

	assign load_ok = !valid_q || out_ready;
	assign pop     = q_not_empty && load_ok;
	assign keep    = (q_head.length < buffer_size) ? q_head.length : buffer_size;

	always_comb begin
		emit     = 1'b1;
		nxt_kind = KIND_END;
		nxt_data = '0;
		nxt_last = 1'b0;
		case (q_head.op)
			OP_HEADER: begin
				nxt_kind = KIND_HEADER;
				nxt_data = {BYTE_W'(0), keep, q_head.msg_type, q_head.win_id};
				nxt_last = keep == '0;
			end
			OP_ERROR: begin
				nxt_kind = KIND_ERROR;
				nxt_data = {BYTE_W'(0), q_head.length, q_head.msg_type, q_head.win_id};
				nxt_last = 1'b1;
			end
			OP_BYTE: begin
				nxt_kind = KIND_PAYLOAD;
				nxt_data = {q_head.data_byte, (3 * WORD_W)'(0)};
				nxt_last = keep_left_q == WORD_W'(1);
				emit     = keep_left_q != '0;
			end
			default: begin
				nxt_kind = KIND_END;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_left_q <= '0;
			valid_q     <= 1'b0;
		end else if (load_ok) begin
			valid_q <= pop && emit;
			if (pop) begin
				case (q_head.op)
					OP_HEADER: keep_left_q <= keep;
					OP_BYTE: begin
						if (keep_left_q != '0) begin
							keep_left_q <= keep_left_q - 1'b1;
						end
					end
					OP_END:    keep_left_q <= '0;
					default:   keep_left_q <= keep_left_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q <= nxt_kind;
			data_q <= nxt_data;
			last_q <= nxt_last;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

endmodule

// ===== rtl/core/envelope_deframer.sv =====
// An accepted item is held in the queue, then in the output register.
// Throughput: one item per cycle unless the queue is full; front and back
// run on their own, parted by a two-entry queue and the output register.
// Only the last header byte gives a result; dropped payload bytes give none.
// Reset (arst_n low, asynchronous): header collection restarts, queue and
// output are emptied, max_payload returns to 65536 and buffer_size to 4096.
// ----------------------------------------------------------------------------
// envelope_deframer
// Length-prefixed frame deframer: 12-byte big-endian header, then payload.
// ----------------------------------------------------------------------------
module envelope_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // [7:0] data_byte
	input  logic [0:0]                 s_tuser,  // [0] action
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [31:0] win_id, [63:32] msg_type, [95:64] length, [103:96] payload_byte
	output logic [ed_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                 m_tuser,  // [1:0] kind
	output logic                       m_tlast,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_addr,
	input  logic [ed_pkg::WORD_W-1:0]  cfg_wdata
);
	import ed_pkg::*;

	logic [WORD_W-1:0] max_payload_q;
	logic [WORD_W-1:0] buffer_size_q;

	logic      q_full;
	logic      q_not_empty;
	logic      push;
	logic      pop;
	op_entry_t push_entry;
	op_entry_t q_head;
	kind_t     out_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= WORD_W'(65536);
			buffer_size_q <= WORD_W'(4096);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_wdata;
				REG_BUFFER_SIZE: buffer_size_q <= cfg_wdata;
				default:         max_payload_q <= max_payload_q;
			endcase
		end
	end

	ed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.action     (s_tuser[0]),
		.data_byte  (s_tdata),
		.max_payload(max_payload_q),
		.q_full     (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	ed_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	ed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.buffer_size(buffer_size_q),
		.out_ready  (m_tready),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_kind   (out_kind),
		.out_data   (m_tdata),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_kind;

`include "envelope_deframer_macros.svh"

	`ED_ASSERT_NOW(a_payload_no_header, m_tvalid && m_tuser == KIND_PAYLOAD, m_tdata[95:0] == '0)
	`ED_ASSERT_NOW(a_end_not_last, m_tvalid && m_tuser == KIND_END, !m_tlast)
	`ED_ASSERT_NOW(a_header_last, m_tvalid && m_tuser == KIND_HEADER, m_tlast == (m_tdata[95:64] == '0))
	`ED_ASSERT_NEXT(a_end_clears, s_tvalid && s_tready && s_tuser[0], u_front.phase_q == PH_HEADER)

endmodule
